FILE: sv/nszl_pkg.sv
package nszl_pkg;

  // Stream widths
  localparam int IN_W  = 16;
  localparam int OUT_W = 64;

  // Gain is a 17-bit quotient, one bit per divider step
  localparam int GAIN_BITS = 17;

  // Short command queue between front and back end
  localparam int QUEUE_DEPTH = 4;
  localparam int QAW         = 2;

  // Distances tested per cycle in the nearest-flag search
  localparam int SCAN_LANES = 4;

  // Floor division by 12 as (x * 171) >> 11, exact for x below 512
  localparam logic [8:0] DIV12_RECIP = 9'd171;
  localparam int         DIV12_SHIFT = 11;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_ADD     = 2'd1,
    ACT_TRIGGER = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    STAT_WRITE_DONE  = 2'd0,
    STAT_LOOKUP_DONE = 2'd1,
    STAT_MAP_EMPTY   = 2'd2,
    STAT_VEL_ZERO    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_CLEAR,
    CMD_ADD,
    CMD_SKIP,
    CMD_VEL_ZERO,
    CMD_TRIGGER
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [6:0] note;
    logic [6:0] velocity;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ROW_WRITE,
    B_KEY_SCAN,
    B_VEL_SCAN,
    B_DONE
  } back_state_t;

  // 2^(r/12) in Q1.24, rounded to nearest
  function automatic logic [24:0] semitone_q24(input logic [3:0] r);
    logic [24:0] v;
    case (r)
      4'd0:    v = 25'd16777216;
      4'd1:    v = 25'd17774841;
      4'd2:    v = 25'd18831788;
      4'd3:    v = 25'd19951585;
      4'd4:    v = 25'd21137968;
      4'd5:    v = 25'd22394897;
      4'd6:    v = 25'd23726566;
      4'd7:    v = 25'd25137421;
      4'd8:    v = 25'd26632170;
      4'd9:    v = 25'd28215802;
      4'd10:   v = 25'd29893600;
      4'd11:   v = 25'd31671166;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/nszl_ram.sv
module nszl_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/nszl_queue.sv
module nszl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  nszl_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output nszl_pkg::cmd_t out_cmd
);

  nszl_pkg::cmd_t entries [nszl_pkg::QUEUE_DEPTH];

  logic [nszl_pkg::QAW-1:0] wr_ptr;
  logic [nszl_pkg::QAW-1:0] rd_ptr;
  logic [nszl_pkg::QAW:0]   count;
  logic                     push;
  logic                     pop;

  assign in_ready  = (count != (nszl_pkg::QAW+1)'(nszl_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/nszl_front.sv
module nszl_front #(
  parameter int NUM_KEYS       = 128,
  parameter int NUM_VELOCITIES = 128
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [nszl_pkg::IN_W-1:0]  in_data,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output nszl_pkg::cmd_t             cmd
);

  localparam logic [8:0] KEY_LIMIT = 9'(NUM_KEYS);
  localparam logic [8:0] VEL_LIMIT = 9'(NUM_VELOCITIES);

  nszl_pkg::action_t   action;
  logic [6:0]          note;
  logic [6:0]          velocity;
  nszl_pkg::cmd_kind_t kind;

  assign action   = nszl_pkg::action_t'(in_data[1:0]);
  assign note     = in_data[8:2];
  assign velocity = in_data[15:9];
  assign in_ready = !cmd_valid || cmd_ready;

  // Classify the item
  always_comb begin
    case (action)
      nszl_pkg::ACT_CLEAR: begin
        kind = nszl_pkg::CMD_CLEAR;
      end
      nszl_pkg::ACT_ADD: begin
        if (({2'b00, note} < KEY_LIMIT) && ({2'b00, velocity} < VEL_LIMIT)) begin
          kind = nszl_pkg::CMD_ADD;
        end else begin
          kind = nszl_pkg::CMD_SKIP;
        end
      end
      nszl_pkg::ACT_TRIGGER: begin
        if (velocity == 7'd0) begin
          kind = nszl_pkg::CMD_VEL_ZERO;
        end else begin
          kind = nszl_pkg::CMD_TRIGGER;
        end
      end
      default: begin
        kind = nszl_pkg::CMD_SKIP;
      end
    endcase
  end

  // Hold the classified command until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd.kind     <= kind;
      cmd.note     <= note;
      cmd.velocity <= velocity;
    end
  end

endmodule

FILE: sv/nszl_back.sv
module nszl_back #(
  parameter int NUM_KEYS        = 128,
  parameter int NUM_VELOCITIES  = 128,
  parameter int RATIO_FRAC_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  nszl_pkg::cmd_t             cmd,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [nszl_pkg::OUT_W-1:0] m_tdata
);

  localparam int KW      = $clog2(NUM_KEYS);
  localparam int VW      = $clog2(NUM_VELOCITIES);
  localparam int SCAN_W  = (NUM_KEYS > NUM_VELOCITIES) ? NUM_KEYS : NUM_VELOCITIES;
  localparam int SIW     = $clog2(SCAN_W);
  localparam int LANES   = nszl_pkg::SCAN_LANES;
  localparam int SH_BIAS = RATIO_FRAC_BITS - 24;
  localparam logic [9:0] KEY_N = 10'(NUM_KEYS);
  localparam logic [9:0] VEL_N = 10'(NUM_VELOCITIES);

  nszl_pkg::back_state_t state;
  nszl_pkg::back_state_t state_next;
  nszl_pkg::cmd_t        cur;
  nszl_pkg::status_t     res_status;

  logic [NUM_KEYS-1:0]   key_present;
  logic                  map_nonempty;
  logic [8:0]            scan_dist;
  logic [SIW-1:0]        chosen_key;
  logic [SIW-1:0]        chosen_vel;

  // Sample row memory, one row of velocity flags per key
  logic                      ram_wr_en;
  logic [KW-1:0]             ram_wr_addr;
  logic [NUM_VELOCITIES-1:0] ram_wr_data;
  logic                      ram_rd_en;
  logic [KW-1:0]             ram_rd_addr;
  logic [NUM_VELOCITIES-1:0] ram_rd_data;

  nszl_ram #(
    .WIDTH (NUM_VELOCITIES),
    .DEPTH (NUM_KEYS)
  ) u_rows (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Nearest-flag search, LANES distances per cycle, lower side first
  logic [SCAN_W-1:0] scan_vec;
  logic [6:0]        scan_start;
  logic [9:0]        scan_n;
  logic [8:0]        lane_dist [LANES];
  logic signed [10:0] lo_pos [LANES];
  logic [9:0]        hi_pos [LANES];
  logic [LANES-1:0]  lo_hit;
  logic [LANES-1:0]  hi_hit;
  logic              scan_found;
  logic [SIW-1:0]    scan_idx;

  assign scan_vec   = (state == nszl_pkg::B_VEL_SCAN) ? SCAN_W'(ram_rd_data)
                                                      : SCAN_W'(key_present);
  assign scan_start = (state == nszl_pkg::B_VEL_SCAN) ? cur.velocity : cur.note;
  assign scan_n     = (state == nszl_pkg::B_VEL_SCAN) ? VEL_N : KEY_N;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      lane_dist[j] = scan_dist + 9'(j);
      lo_pos[j]    = $signed({4'b0000, scan_start}) - $signed({2'b00, lane_dist[j]});
      hi_pos[j]    = {3'b000, scan_start} + {1'b0, lane_dist[j]};
      lo_hit[j]    = !lo_pos[j][10] && (lo_pos[j][9:0] < scan_n) &&
                     scan_vec[lo_pos[j][SIW-1:0]];
      hi_hit[j]    = (hi_pos[j] < scan_n) && scan_vec[hi_pos[j][SIW-1:0]];
    end
  end

  always_comb begin
    scan_idx = '0;
    for (int j = LANES - 1; j >= 0; j--) begin
      if (hi_hit[j]) begin
        scan_idx = hi_pos[j][SIW-1:0];
      end
      if (lo_hit[j]) begin
        scan_idx = lo_pos[j][SIW-1:0];
      end
    end
    scan_found = (|lo_hit) || (|hi_hit);
  end

  // Split note - key into 12*q + r with floor division
  logic signed [10:0] diff;
  logic               diff_neg;
  logic [9:0]         diff_mag;
  logic [9:0]         div_num;
  logic [18:0]        div_prod;
  logic [6:0]         q_mag;
  logic signed [7:0]  q_next;
  logic signed [10:0] r_full;
  logic signed [7:0]  q_reg;
  logic [3:0]         r_reg;

  always_comb begin
    diff     = $signed({4'b0000, cur.note}) - $signed({3'b000, 8'(chosen_key)});
    diff_neg = diff[10];
    diff_mag = diff_neg ? 10'(-diff) : 10'(diff);
    div_num  = diff_neg ? (diff_mag + 10'd11) : diff_mag;
    div_prod = {9'd0, div_num} * {10'd0, nszl_pkg::DIV12_RECIP};
    q_mag    = 7'(div_prod >> nszl_pkg::DIV12_SHIFT);
    q_next   = diff_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    r_full   = diff - 11'(q_next * 8'sd12);
  end

  always_ff @(posedge clk) begin
    q_reg <= q_next;
    r_reg <= r_full[3:0];
  end

  // Shift the semitone entry by q plus the fraction offset
  logic signed [7:0] sh;
  logic [7:0]        sh_right;
  logic [63:0]       t64;
  logic [63:0]       t_left;
  logic [63:0]       t_right;
  logic [30:0]       pitch;

  always_comb begin
    sh       = q_reg + 8'(SH_BIAS);
    sh_right = 8'(-sh);
    t64      = 64'(nszl_pkg::semitone_q24(r_reg));
    t_left   = t64 << sh[4:0];
    t_right  = (t64 + (64'd1 << (sh_right[5:0] - 6'd1))) >> sh_right[5:0];
    if (!sh[7]) begin
      if ((sh > 8'sd31) || (t_left > 64'h7FFF_FFFF)) begin
        pitch = 31'h7FFF_FFFF;
      end else begin
        pitch = t_left[30:0];
      end
    end else if (sh_right > 8'd62) begin
      pitch = '0;
    end else begin
      pitch = t_right[30:0];
    end
  end

  // Gain divider: (65536 + v/2) / v, one quotient bit per cycle
  logic                                  div_busy;
  logic [4:0]                            div_count;
  logic [nszl_pkg::GAIN_BITS-1:0]        div_dvd;
  logic [6:0]                            div_rem;
  logic [7:0]                            div_trial;
  logic                                  div_qbit;

  assign div_trial = {div_rem, div_dvd[nszl_pkg::GAIN_BITS-1]};
  assign div_qbit  = (div_trial >= {1'b0, cur.velocity});

  // Next state
  logic out_load;

  always_comb begin
    state_next = state;
    case (state)
      nszl_pkg::B_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            nszl_pkg::CMD_ADD:     state_next = nszl_pkg::B_ROW_WRITE;
            nszl_pkg::CMD_TRIGGER: state_next = map_nonempty ? nszl_pkg::B_KEY_SCAN
                                                             : nszl_pkg::B_DONE;
            default:               state_next = nszl_pkg::B_DONE;
          endcase
        end
      end
      nszl_pkg::B_ROW_WRITE: begin
        state_next = nszl_pkg::B_DONE;
      end
      nszl_pkg::B_KEY_SCAN: begin
        if (scan_found) begin
          state_next = nszl_pkg::B_VEL_SCAN;
        end
      end
      nszl_pkg::B_VEL_SCAN: begin
        if (scan_found) begin
          state_next = nszl_pkg::B_DONE;
        end
      end
      nszl_pkg::B_DONE: begin
        if (out_load) begin
          state_next = nszl_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = nszl_pkg::B_IDLE;
      end
    endcase
  end

  // State outputs: queue pop, memory ports, result load
  always_comb begin
    cmd_ready   = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = KW'(cmd.note);
    ram_wr_en   = 1'b0;
    ram_wr_addr = KW'(cur.note);
    ram_wr_data = (key_present[KW'(cur.note)] ? ram_rd_data : '0) |
                  (NUM_VELOCITIES'(1) << VW'(cur.velocity));
    out_load    = 1'b0;
    case (state)
      nszl_pkg::B_IDLE: begin
        cmd_ready = 1'b1;
        ram_rd_en = cmd_valid && (cmd.kind == nszl_pkg::CMD_ADD);
      end
      nszl_pkg::B_ROW_WRITE: begin
        ram_wr_en = 1'b1;
      end
      nszl_pkg::B_KEY_SCAN: begin
        ram_rd_en   = scan_found;
        ram_rd_addr = KW'(scan_idx);
      end
      nszl_pkg::B_DONE: begin
        out_load = (!m_tvalid || m_tready) && !div_busy;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= nszl_pkg::B_IDLE;
      key_present  <= '0;
      map_nonempty <= 1'b0;
      div_busy     <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == nszl_pkg::B_IDLE) && cmd_valid) begin
        if (cmd.kind == nszl_pkg::CMD_CLEAR) begin
          key_present  <= '0;
          map_nonempty <= 1'b0;
        end
        if ((cmd.kind == nszl_pkg::CMD_TRIGGER) && map_nonempty) begin
          div_busy <= 1'b1;
        end
      end else if (div_busy && (div_count == 5'(nszl_pkg::GAIN_BITS - 1))) begin
        div_busy <= 1'b0;
      end
      if (state == nszl_pkg::B_ROW_WRITE) begin
        key_present[KW'(cur.note)] <= 1'b1;
        map_nonempty               <= 1'b1;
      end
    end
  end

  // Command, search and divider datapath
  always_ff @(posedge clk) begin
    if ((state == nszl_pkg::B_IDLE) && cmd_valid) begin
      cur       <= cmd;
      scan_dist <= '0;
      div_count <= '0;
      div_rem   <= '0;
      div_dvd   <= nszl_pkg::GAIN_BITS'(65536) + {11'd0, cmd.velocity[6:1]};
      case (cmd.kind)
        nszl_pkg::CMD_TRIGGER:  res_status <= map_nonempty ? nszl_pkg::STAT_LOOKUP_DONE
                                                           : nszl_pkg::STAT_MAP_EMPTY;
        nszl_pkg::CMD_VEL_ZERO: res_status <= nszl_pkg::STAT_VEL_ZERO;
        default:                res_status <= nszl_pkg::STAT_WRITE_DONE;
      endcase
    end else begin
      if (div_busy) begin
        div_rem   <= div_qbit ? 7'(div_trial - {1'b0, cur.velocity}) : div_trial[6:0];
        div_dvd   <= {div_dvd[nszl_pkg::GAIN_BITS-2:0], div_qbit};
        div_count <= div_count + 5'd1;
      end
      if ((state == nszl_pkg::B_KEY_SCAN) || (state == nszl_pkg::B_VEL_SCAN)) begin
        if (scan_found) begin
          scan_dist <= '0;
        end else begin
          scan_dist <= scan_dist + 9'(LANES);
        end
      end
      if ((state == nszl_pkg::B_KEY_SCAN) && scan_found) begin
        chosen_key <= scan_idx;
      end
      if ((state == nszl_pkg::B_VEL_SCAN) && scan_found) begin
        chosen_vel <= scan_idx;
      end
    end
  end

  // Output register: load a finished result, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (res_status == nszl_pkg::STAT_LOOKUP_DONE) begin
        m_tdata <= {div_dvd, pitch, 7'(chosen_vel), 7'(chosen_key), res_status};
      end else begin
        m_tdata <= {62'd0, res_status};
      end
    end
  end

endmodule

FILE: sv/nearest_sample_zone_lookup.sv
// A lookup on a non-empty map searches outward from the note for the nearest set key flag,
// then from the velocity for the nearest set velocity flag in that key's row, and its result
// also waits for the 17-step gain divider. The back end takes one item at a time; the queue
// lets the front keep accepting items while it has room.
// Reset clears the key present and map-nonempty flags; rows are used only under a set flag.
module nearest_sample_zone_lookup #(
  parameter int NUM_KEYS        = 128,
  parameter int NUM_VELOCITIES  = 128,
  parameter int RATIO_FRAC_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // action[1:0], note[8:2], velocity[15:9]
  input  logic [nszl_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // status[1:0], chosen_key[8:2], chosen_velocity[15:9], pitch_ratio[46:16],
  // gain[63:47]
  output logic [nszl_pkg::OUT_W-1:0] m_tdata
);

  logic           front_valid;
  logic           front_ready;
  nszl_pkg::cmd_t front_cmd;
  logic           back_valid;
  logic           back_ready;
  nszl_pkg::cmd_t back_cmd;

  // Accept and classify items
  nszl_front #(
    .NUM_KEYS       (NUM_KEYS),
    .NUM_VELOCITIES (NUM_VELOCITIES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  // Decouple front from back
  nszl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_cmd    (front_cmd),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_cmd   (back_cmd)
  );

  // Map updates, searches and result math
  nszl_back #(
    .NUM_KEYS        (NUM_KEYS),
    .NUM_VELOCITIES  (NUM_VELOCITIES),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

FILE: sv/nszl_check.sv
module nszl_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [nszl_pkg::IN_W-1:0]  s_tdata,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [nszl_pkg::OUT_W-1:0] m_tdata
);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("stalled input item changed");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Any result other than a finished lookup carries only its status
  a_other_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != nszl_pkg::STAT_LOOKUP_DONE) |-> (m_tdata[63:2] == '0))
    else $error("nonzero fields on a status-only result");

  // A finished lookup has a gain in range
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == nszl_pkg::STAT_LOOKUP_DONE) |->
      (m_tdata[63:47] != '0) && (m_tdata[63:47] <= 17'd65536))
    else $error("lookup gain out of range");

endmodule

bind nearest_sample_zone_lookup nszl_check u_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: tb/zone_lookup_checker.sv
module zone_lookup_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  // action[1:0], note[8:2], velocity[15:9]
  input  logic [nszl_pkg::IN_W-1:0]   s_tdata,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  // status[1:0], chosen_key[8:2], chosen_velocity[15:9], pitch_ratio[46:16],
  // gain[63:47]
  input  logic [nszl_pkg::OUT_W-1:0]  m_tdata,
  output int                          fail_count,
  output int                          results_seen,
  output int                          lookups_hit,
  output int                          zones_owed
);
  import nszl_pkg::*;

  localparam int KEYS      = 128;
  localparam int VELS      = 128;
  localparam int FRAC_BITS = 20;
  localparam logic [30:0] RATIO_MAX = 31'h7FFF_FFFF;

  // 2^(r/12) in Q1.24
  localparam logic [24:0] STEP_Q24 [12] = '{
    25'd16777216, 25'd17774841, 25'd18831788, 25'd19951585,
    25'd21137968, 25'd22394897, 25'd23726566, 25'd25137421,
    25'd26632170, 25'd28215802, 25'd29893600, 25'd31671166
  };

  typedef struct packed {
    status_t     status;
    logic [6:0]  key;
    logic [6:0]  vel;
    logic [30:0] ratio;
    logic [16:0] gain;
  } zone_result_t;

  // Shadow of the sample map
  logic [KEYS-1:0] key_map;
  logic [VELS-1:0] vel_rows [KEYS];

  // Results owed by the block, oldest first
  zone_result_t pending_zones [$];

  initial begin
    fail_count   = 0;
    results_seen = 0;
    lookups_hit  = 0;
    zones_owed   = 0;
  end

  // Nearest set flag to start, widening one step at a time, lower side first
  function automatic int nearest_flag(input logic [127:0] flags, input int start);
    for (int d = 0; d <= start + 128; d++) begin
      if (start - d >= 0 && flags[start - d])
        return start - d;
      if (start + d < 128 && flags[start + d])
        return start + d;
    end
    return -1;
  endfunction

  // 2^(diff/12) with FRAC_BITS fraction bits, right shifts round half up
  function automatic logic [30:0] pitch_ratio_for(input int diff);
    int q;
    int r;
    int sh;
    logic [63:0] t;
    q  = (diff >= 0) ? diff / 12 : -((-diff + 11) / 12);
    r  = diff - 12 * q;
    t  = 64'(STEP_Q24[r]);
    sh = q + FRAC_BITS - 24;
    if (sh > 31)
      return RATIO_MAX;
    if (sh >= 0) begin
      t = t << sh;
      if (t > 64'(RATIO_MAX))
        t = 64'(RATIO_MAX);
    end else if (-sh > 62) begin
      return '0;
    end else begin
      t = (t + (64'd1 << (-sh - 1))) >> (-sh);
    end
    return t[30:0];
  endfunction

  // Work out the result of one trigger against the current map
  function automatic zone_result_t predict_zone(input logic [6:0] note, input logic [6:0] vel);
    zone_result_t res;
    int key;
    int cv;
    int v;
    res = '0;
    v   = int'(vel);
    if (v == 0) begin
      res.status = STAT_VEL_ZERO;
      return res;
    end
    key = nearest_flag(key_map, int'(note));
    if (key < 0) begin
      res.status = STAT_MAP_EMPTY;
      return res;
    end
    cv = nearest_flag(vel_rows[key], v);
    if (cv < 0) begin
      res.status = STAT_MAP_EMPTY;
      return res;
    end
    res.status = STAT_LOOKUP_DONE;
    res.key    = 7'(key);
    res.vel    = 7'(cv);
    res.ratio  = pitch_ratio_for(int'(note) - key);
    res.gain   = 17'((65536 + v / 2) / v);
    return res;
  endfunction

  // Check results, then predict for accepted items
  always @(posedge clk) begin : watch
    zone_result_t got;
    zone_result_t want;
    logic [1:0]   act;
    logic [6:0]   note;
    logic [6:0]   vel;
    logic         bad;
    bad = 1'b0;
    if (rst) begin
      key_map = '0;
      for (int k = 0; k < KEYS; k++)
        vel_rows[k] = '0;
      pending_zones.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tdata[1:0]);
        got.key    = m_tdata[8:2];
        got.vel    = m_tdata[15:9];
        got.ratio  = m_tdata[46:16];
        got.gain   = m_tdata[63:47];
        if (pending_zones.size() == 0) begin
          $display("%0t: unexpected result status %0d key %0d vel %0d ratio %0d gain %0d",
                   $time, got.status, got.key, got.vel, got.ratio, got.gain);
          bad = 1'b1;
        end else begin
          want = pending_zones.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected status %0d key %0d vel %0d ratio %0d gain %0d",
                     $time, want.status, want.key, want.vel, want.ratio, want.gain);
            $display("%0t:          actual   status %0d key %0d vel %0d ratio %0d gain %0d",
                     $time, got.status, got.key, got.vel, got.ratio, got.gain);
            bad = 1'b1;
          end
        end
        results_seen <= results_seen + 1;
        if (got.status == STAT_LOOKUP_DONE)
          lookups_hit <= lookups_hit + 1;
      end
      if (s_tvalid && s_tready) begin
        act  = s_tdata[1:0];
        note = s_tdata[8:2];
        vel  = s_tdata[15:9];
        want = '0;
        case (act)
          ACT_CLEAR: begin
            key_map = '0;
            for (int k = 0; k < KEYS; k++)
              vel_rows[k] = '0;
          end
          ACT_ADD: begin
            key_map[note]       = 1'b1;
            vel_rows[note][vel] = 1'b1;
          end
          ACT_TRIGGER: begin
            want = predict_zone(note, vel);
          end
          default: begin
          end
        endcase
        pending_zones = {pending_zones, want};
      end
    end
    if (bad)
      fail_count <= fail_count + 1;
    zones_owed <= pending_zones.size();
  end

endmodule

FILE: tb/tb_nearest_sample_zone_lookup.sv
module tb_nearest_sample_zone_lookup;
  import nszl_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS  = 410;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  int useful_sent    = 0;
  int lookups_sent   = 0;
  int writes_sent    = 0;
  int unused_sent    = 0;

  int fail_count;
  int results_seen;
  int lookups_hit;
  int zones_owed;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count cycles and stall the result side at random
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  nearest_sample_zone_lookup DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  zone_lookup_checker u_zone_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .fail_count   (fail_count),
    .results_seen (results_seen),
    .lookups_hit  (lookups_hit),
    .zones_owed   (zones_owed)
  );

  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_item(input logic [1:0] act, input logic [6:0] note,
                           input logic [6:0] vel);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {vel, note, act};
    do @(posedge clk); while (!s_tready);
    case (act)
      ACT_TRIGGER: begin
        lookups_sent++;
        useful_sent++;
      end
      ACT_CLEAR, ACT_ADD: begin
        writes_sent++;
        useful_sent++;
      end
      default: unused_sent++;
    endcase
  endtask

  // Drop valid and wait until the block owes nothing
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (zones_owed != 0)
      @(posedge clk);
  endtask

  // Key near center, clamped to the key range
  function automatic logic [6:0] near_key(input int center, input int spread);
    int k;
    k = center + int'($urandom_range(2 * spread)) - spread;
    if (k < 0)
      k = 0;
    if (k > 127)
      k = 127;
    return 7'(k);
  endfunction

  // Mostly clear/fill/trigger sessions, some noise and broken sessions
  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
    int first;
    int n_add;
    int n_trig;
    int center;
    int spread;
    bit paused;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    first  = useful_sent;
    paused = 1'b0;
    while (useful_sent - first < n_items) begin
      if (!paused && useful_sent - first >= n_items / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
      case ($urandom_range(9))
        0: begin
          repeat ($urandom_range(1, 4))
            send_item(2'($urandom_range(3)), 7'($urandom), 7'($urandom));
        end
        1: begin
          send_item(ACT_CLEAR, 7'($urandom), 7'($urandom));
          send_item(ACT_TRIGGER, 7'($urandom), 7'($urandom));
        end
        default: begin
          if ($urandom_range(3) != 0)
            send_item(ACT_CLEAR, 7'($urandom), 7'($urandom));
          n_add  = ($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
          center = $urandom_range(127);
          spread = ($urandom_range(1) == 0) ? 6 : 127;
          repeat (n_add)
            send_item(ACT_ADD, near_key(center, spread), 7'($urandom));
          n_trig = $urandom_range(2, 8);
          repeat (n_trig)
            send_item(ACT_TRIGGER,
                      ($urandom_range(4) == 0) ? 7'($urandom) : near_key(center, 12),
                      ($urandom_range(15) == 0) ? 7'd0 : 7'($urandom_range(1, 127)));
        end
      endcase
    end
  endtask

  // Stop a hung run
  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("%0t: run timed out after %0d cycles", $time, cycle_count);
    $display("** nearest_sample_zone_lookup: FAILED **");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed corners: empty map, zero velocity, ties, farthest searches
    send_item(ACT_TRIGGER, 7'd0, 7'd1);
    send_item(ACT_TRIGGER, 7'd127, 7'd0);
    send_item(ACT_UNUSED, 7'd127, 7'd127);
    send_item(ACT_ADD, 7'd0, 7'd0);
    send_item(ACT_TRIGGER, 7'd127, 7'd127);
    send_item(ACT_TRIGGER, 7'd0, 7'd1);
    send_item(ACT_TRIGGER, 7'd5, 7'd0);
    send_item(ACT_ADD, 7'd127, 7'd127);
    send_item(ACT_TRIGGER, 7'd64, 7'd64);
    send_item(ACT_TRIGGER, 7'd63, 7'd64);
    send_item(ACT_CLEAR, 7'd127, 7'd127);
    send_item(ACT_TRIGGER, 7'd64, 7'd1);
    send_item(ACT_ADD, 7'd127, 7'd0);
    send_item(ACT_TRIGGER, 7'd0, 7'd127);
    send_item(ACT_ADD, 7'd10, 7'd5);
    send_item(ACT_ADD, 7'd12, 7'd9);
    send_item(ACT_ADD, 7'd10, 7'd9);
    send_item(ACT_TRIGGER, 7'd11, 7'd7);
    send_item(ACT_ADD, 7'd10, 7'd5);
    send_item(ACT_TRIGGER, 7'd12, 7'd127);
    send_item(ACT_CLEAR, 7'd0, 7'd0);
    send_item(ACT_UNUSED, 7'd0, 7'd0);

    // Random sessions under each handshake mix
    run_phase(0, 0, PHASE_ITEMS);
    run_phase(47, 0, PHASE_ITEMS);
    run_phase(0, 47, PHASE_ITEMS);
    run_phase(36, 36, PHASE_ITEMS);

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d lookups, %0d map writes, %0d unused actions, four idle mixes",
             useful_sent + unused_sent, lookups_sent, writes_sent, unused_sent);
    $display("Compared %0d results, %0d of them completed lookups", results_seen, lookups_hit);
    if (fail_count == 0 && zones_owed == 0)
      $display("** nearest_sample_zone_lookup: PASSED **");
    else
      $display("** nearest_sample_zone_lookup: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
sv/nszl_pkg.sv
sv/nszl_ram.sv
sv/nszl_queue.sv
sv/nszl_front.sv
sv/nszl_back.sv
sv/nearest_sample_zone_lookup.sv
sv/nszl_check.sv
tb/zone_lookup_checker.sv
tb/tb_nearest_sample_zone_lookup.sv
